>>> src/gpioc_pkg.sv
// Shared types and constants for the GPIO register controller.
// Holds the request and response transfer structs and the register word map.
// No dependencies.
`default_nettype none

package gpioc_pkg;

    // Field widths of one transfer.
    localparam int ADDR_W     = 6;
    localparam int WORD_W     = 32;
    localparam int OUT_PINS   = 54;
    localparam int VEC_W      = 64;

    // Function select layout: ten 3-bit fields packed into each word.
    localparam int FSEL_BITS     = 3;
    localparam int FSEL_PER_WORD = 10;
    localparam int FSEL_WORDS    = 6;
    localparam int FSEL_W        = FSEL_BITS * FSEL_PER_WORD;
    localparam int FSEL_IDX_W    = 3;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Function code that turns a pin into an output.
    localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

    // Register word map.
    localparam logic [ADDR_W-1:0] ADDR_FSEL_FIRST = 6'd0;
    localparam logic [ADDR_W-1:0] ADDR_FSEL_LAST  = 6'd5;
    localparam logic [ADDR_W-1:0] ADDR_SET0       = 6'd7;
    localparam logic [ADDR_W-1:0] ADDR_SET1       = 6'd8;
    localparam logic [ADDR_W-1:0] ADDR_CLR0       = 6'd10;
    localparam logic [ADDR_W-1:0] ADDR_CLR1       = 6'd11;
    localparam logic [ADDR_W-1:0] ADDR_LEV0       = 6'd13;
    localparam logic [ADDR_W-1:0] ADDR_LEV1       = 6'd14;
    localparam logic [ADDR_W-1:0] ADDR_PULL_CTL   = 6'd37;
    localparam logic [ADDR_W-1:0] ADDR_PCLK0      = 6'd38;
    localparam logic [ADDR_W-1:0] ADDR_PCLK1      = 6'd39;

    // One bus access plus the sampled pin levels.
    typedef struct packed {
        logic                req_type;
        logic [ADDR_W-1:0]   word_addr;
        logic [WORD_W-1:0]   write_data;
        logic [OUT_PINS-1:0] pin_levels;
    } gpioc_req_t;

    // Read data and the pin control vectors after the access.
    typedef struct packed {
        logic [WORD_W-1:0]   read_data;
        logic [OUT_PINS-1:0] pin_drive;
        logic [OUT_PINS-1:0] pin_output_enable;
        logic [OUT_PINS-1:0] pull_up_enable;
        logic [OUT_PINS-1:0] pull_down_enable;
    } gpioc_rsp_t;

endpackage

`default_nettype wire

>>> src/gpioc_core.sv
// Register file and access decode of the GPIO register controller.
// Holds function select, output latch and pull state; depends on gpioc_pkg.
// The response is combinational from the request and the updated state.
`default_nettype none

module gpioc_core #(
    parameter int NUM_PINS = 54
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire gpioc_pkg::gpioc_req_t req,
    output gpioc_pkg::gpioc_rsp_t   rsp
);

    localparam logic [gpioc_pkg::VEC_W-1:0] PIN_MASK64 =
        {gpioc_pkg::VEC_W{1'b1}} >> (gpioc_pkg::VEC_W - NUM_PINS);

    logic [gpioc_pkg::FSEL_W-1:0] fsel_reg  [gpioc_pkg::FSEL_WORDS];
    logic [gpioc_pkg::FSEL_W-1:0] fsel_next [gpioc_pkg::FSEL_WORDS];
    logic [gpioc_pkg::FSEL_W-1:0] fsel_mask [gpioc_pkg::FSEL_WORDS];
    logic [NUM_PINS-1:0]          latch_reg, latch_next;
    logic [1:0]                   pull_ctl_reg, pull_ctl_next;
    logic [NUM_PINS-1:0]          pull_lo_reg, pull_lo_next;
    logic [NUM_PINS-1:0]          pull_hi_reg, pull_hi_next;

    logic                         is_write;
    logic                         bank_hi;
    logic [gpioc_pkg::VEC_W-1:0]  bank_vec64;
    logic [NUM_PINS-1:0]          bank_vec;
    logic [gpioc_pkg::VEC_W-1:0]  levels64;
    logic [gpioc_pkg::WORD_W-1:0] rd;
    logic [gpioc_pkg::FSEL_IDX_W-1:0] fidx;
    logic [gpioc_pkg::OUT_PINS-1:0] oe;
    logic [gpioc_pkg::VEC_W-1:0]  drive64, up64, down64;

    // Per-word mask of function fields that belong to existing pins.
    always_comb
    begin
        for (int w = 0; w < gpioc_pkg::FSEL_WORDS; w++)
        begin
            for (int k = 0; k < gpioc_pkg::FSEL_PER_WORD; k++)
            begin
                fsel_mask[w][k*gpioc_pkg::FSEL_BITS +: gpioc_pkg::FSEL_BITS] =
                    (w * gpioc_pkg::FSEL_PER_WORD + k < NUM_PINS) ? 3'b111 : 3'b000;
            end
        end
    end

    // Bank placement of the write data and the masked pin levels.
    assign is_write   = (req.req_type == gpioc_pkg::REQ_WRITE);
    assign bank_hi    = (req.word_addr == gpioc_pkg::ADDR_SET1)
                     || (req.word_addr == gpioc_pkg::ADDR_CLR1)
                     || (req.word_addr == gpioc_pkg::ADDR_LEV1)
                     || (req.word_addr == gpioc_pkg::ADDR_PCLK1);
    assign bank_vec64 = bank_hi ? {req.write_data, {gpioc_pkg::WORD_W{1'b0}}}
                                : {{gpioc_pkg::WORD_W{1'b0}}, req.write_data};
    assign bank_vec   = bank_vec64[NUM_PINS-1:0];
    assign levels64   = gpioc_pkg::VEC_W'(req.pin_levels) & PIN_MASK64;
    assign fidx       = req.word_addr[gpioc_pkg::FSEL_IDX_W-1:0];

    // Access decode and next state.
    always_comb
    begin
        fsel_next     = fsel_reg;
        latch_next    = latch_reg;
        pull_ctl_next = pull_ctl_reg;
        pull_lo_next  = pull_lo_reg;
        pull_hi_next  = pull_hi_reg;
        rd            = '0;
        unique case (req.word_addr) inside
            [gpioc_pkg::ADDR_FSEL_FIRST:gpioc_pkg::ADDR_FSEL_LAST]:
            begin
                if (is_write)
                begin
                    fsel_next[fidx] = req.write_data[gpioc_pkg::FSEL_W-1:0]
                                    & fsel_mask[fidx];
                end
                else
                begin
                    rd = gpioc_pkg::WORD_W'(fsel_reg[fidx]);
                end
            end
            gpioc_pkg::ADDR_SET0, gpioc_pkg::ADDR_SET1:
            begin
                if (is_write)
                begin
                    latch_next = latch_reg | bank_vec;
                end
            end
            gpioc_pkg::ADDR_CLR0, gpioc_pkg::ADDR_CLR1:
            begin
                if (is_write)
                begin
                    latch_next = latch_reg & ~bank_vec;
                end
            end
            gpioc_pkg::ADDR_LEV0, gpioc_pkg::ADDR_LEV1:
            begin
                rd = bank_hi ? levels64[gpioc_pkg::VEC_W-1:gpioc_pkg::WORD_W]
                             : levels64[gpioc_pkg::WORD_W-1:0];
            end
            gpioc_pkg::ADDR_PULL_CTL:
            begin
                if (is_write)
                begin
                    pull_ctl_next = req.write_data[1:0];
                end
                else
                begin
                    rd = gpioc_pkg::WORD_W'(pull_ctl_reg);
                end
            end
            gpioc_pkg::ADDR_PCLK0, gpioc_pkg::ADDR_PCLK1:
            begin
                if (is_write)
                begin
                    pull_lo_next = (pull_lo_reg & ~bank_vec)
                                 | (bank_vec & {NUM_PINS{pull_ctl_reg[0]}});
                    pull_hi_next = (pull_hi_reg & ~bank_vec)
                                 | (bank_vec & {NUM_PINS{pull_ctl_reg[1]}});
                end
            end
            default:
            begin
                rd = '0;
            end
        endcase
    end

    // State registers advance only when the access completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < gpioc_pkg::FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg    <= '0;
            pull_ctl_reg <= '0;
            pull_lo_reg  <= '0;
            pull_hi_reg  <= '0;
        end
        else if (en)
        begin
            fsel_reg     <= fsel_next;
            latch_reg    <= latch_next;
            pull_ctl_reg <= pull_ctl_next;
            pull_lo_reg  <= pull_lo_next;
            pull_hi_reg  <= pull_hi_next;
        end
    end

    // Output enable from the updated function fields.
    always_comb
    begin
        for (int p = 0; p < gpioc_pkg::OUT_PINS; p++)
        begin
            oe[p] = (fsel_next[gpioc_pkg::FSEL_IDX_W'(p / gpioc_pkg::FSEL_PER_WORD)]
                     [(p % gpioc_pkg::FSEL_PER_WORD) * gpioc_pkg::FSEL_BITS
                      +: gpioc_pkg::FSEL_BITS] == gpioc_pkg::FSEL_OUTPUT);
        end
    end

    // Response vectors, cut to the pin width of the bus.
    assign drive64 = gpioc_pkg::VEC_W'(latch_next);
    assign up64    = gpioc_pkg::VEC_W'(pull_hi_next & ~pull_lo_next);
    assign down64  = gpioc_pkg::VEC_W'(pull_lo_next & ~pull_hi_next);

    assign rsp.read_data         = is_write ? '0 : rd;
    assign rsp.pin_drive         = drive64[gpioc_pkg::OUT_PINS-1:0];
    assign rsp.pin_output_enable = oe;
    assign rsp.pull_up_enable    = up64[gpioc_pkg::OUT_PINS-1:0];
    assign rsp.pull_down_enable  = down64[gpioc_pkg::OUT_PINS-1:0];

endmodule

`default_nettype wire

>>> src/gpio_register_controller.sv
// Top level of the GPIO register controller: input and result registers.
// Depends on gpioc_pkg and gpioc_core.
//
//  Channel  Valid      Stall      Payload               Transfer
//  request  req_valid  req_stall  req (gpioc_req_t)     req_valid & !req_stall
//  response rsp_valid  rsp_stall  rsp (gpioc_rsp_t)     rsp_valid & !rsp_stall
//
// One access per cycle while the response is not stalled; an access is held
// first in the input register and then in the result register, and its
// response is valid once it reaches the result register.
// The register file updates as an access moves from the input register into
// the result register. Reset clears the register file and both valid flags.
// A stalled response holds the result register; the input register then
// holds one more access and req_stall rises only when both are full.
`default_nettype none

module gpio_register_controller #(
    parameter int NUM_PINS = 54
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_stall,
    input  wire gpioc_pkg::gpioc_req_t req,
    output logic                    rsp_valid,
    input  wire                     rsp_stall,
    output gpioc_pkg::gpioc_rsp_t   rsp
);

    logic                  in_valid_reg;
    gpioc_pkg::gpioc_req_t in_reg;
    logic                  out_valid_reg;
    gpioc_pkg::gpioc_rsp_t out_reg;
    gpioc_pkg::gpioc_rsp_t core_rsp;
    logic                  advance;
    logic                  fire;

    // Pipeline flow control.
    assign advance   = !out_valid_reg || !rsp_stall;
    assign fire      = in_valid_reg && advance;
    assign req_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_reg <= req;
        end
    end

    // Decode and register state.
    gpioc_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (fire),
        .req   (in_reg),
        .rsp   (core_rsp)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= core_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
